/* rtl/core/pba_pkg.sv */
// Package for the page bitmap allocator: request and response types,
// action and configuration codes, and default sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pba_pkg;

  // Default map geometry.
  localparam int unsigned PBA_MAX_PAGES     = 65536;
  localparam int unsigned PBA_MAP_WORD_BITS = 64;

  // Field widths.
  localparam int unsigned PBA_ACT_W   = 3;
  localparam int unsigned PBA_PIDX_W  = 16;
  localparam int unsigned PBA_CNT_W   = 17;
  localparam int unsigned PBA_CFG_W   = 17;
  localparam int unsigned PBA_CFG_IDX_W = 1;

  // Reset value of both configuration registers.
  localparam logic [PBA_CFG_W-1:0] PBA_CFG_RST = 17'h10000;

  typedef enum logic [PBA_ACT_W-1:0] {
    ACT_INIT      = 3'd0,
    ACT_ALLOC     = 3'd1,
    ACT_FREE      = 3'd2,
    ACT_LOCK      = 3'd3,
    ACT_RESERVE   = 3'd4,
    ACT_UNRESERVE = 3'd5
  } pba_action_e;

  typedef enum logic [PBA_CFG_IDX_W-1:0] {
    CFG_SCAN_PAGES  = 1'b0,
    CFG_TOTAL_PAGES = 1'b1
  } pba_cfg_e;

  typedef struct packed {
    logic [PBA_ACT_W-1:0]  action;
    logic [PBA_PIDX_W-1:0] page_index;
    logic [PBA_CNT_W-1:0]  page_count;
  } pba_req_t;

  typedef struct packed {
    logic [PBA_PIDX_W-1:0] alloc_page;
    logic                  alloc_ok;
    logic [PBA_CNT_W-1:0]  free_pages;
    logic [PBA_CNT_W-1:0]  used_pages;
    logic [PBA_CNT_W-1:0]  reserved_pages;
  } pba_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/pba_map.sv */
// Page map storage: one write port and one registered read port.
// Stands alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module pba_map #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = 10
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/pba_seq.sv */
// Sequencer of the page bitmap allocator: clear sweep, start-page divider,
// word read/modify/write walk and the page counters. Uses pba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pba_seq import pba_pkg::*; #(
  parameter int unsigned MAX_PAGES     = PBA_MAX_PAGES,
  parameter int unsigned MAP_WORD_BITS = PBA_MAP_WORD_BITS,
  localparam int unsigned MAP_WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS,
  localparam int unsigned WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire pba_req_t                 req_i,
  input  wire logic [PBA_CFG_W-1:0]     scan_pages_i,
  input  wire logic [PBA_CFG_W-1:0]     total_pages_i,
  output logic                          busy_o,
  output logic                          done_o,
  output pba_rsp_t                      rsp_o,
  output logic                          mem_we_o,
  output logic [WAW-1:0]                mem_waddr_o,
  output logic [MAP_WORD_BITS-1:0]      mem_wdata_o,
  output logic                          mem_re_o,
  output logic [WAW-1:0]                mem_raddr_o,
  input  wire logic [MAP_WORD_BITS-1:0] mem_rdata_i
);

  localparam int unsigned BW    = $clog2(MAP_WORD_BITS);
  localparam int unsigned PSPAN = (MAX_PAGES > 65536) ? MAX_PAGES : 65536;
  localparam int unsigned PW    = $clog2(PSPAN + 1);
  localparam int unsigned RSH   = PBA_PIDX_W + BW;
  localparam int unsigned RCW   = PBA_PIDX_W + 2;

  localparam logic [BW-1:0]   BLAST_C = BW'(MAP_WORD_BITS - 1);
  localparam logic [PW-1:0]   MAXP_C = PW'(MAX_PAGES);
  localparam logic [PW-1:0]   WSTEP_C = PW'(MAP_WORD_BITS);
  localparam logic [WAW-1:0]  WLAST_C = WAW'(MAP_WORDS - 1);
  localparam logic [PBA_CNT_W-1:0] ONE_C = PBA_CNT_W'(1);
  // Reciprocal of the word size, exact for every 16-bit page number.
  localparam logic [RCW-1:0]  RECIP_C = RCW'((64'd1 << RSH) / MAP_WORD_BITS + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CLEAR = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_READ  = 8'b0000_1000,
    S_LOAD  = 8'b0001_0000,
    S_WALK  = 8'b0010_0000,
    S_WRITE = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } pba_state_e;

  pba_state_e state_q, state_d;
  logic init_q, init_d;
  logic alloc_q, alloc_d;
  logic run_q, run_d;
  logic set_q, set_d;
  logic rsel_q, rsel_d;
  logic fin_q, fin_d;
  logic ok_q, ok_d;
  logic [PBA_PIDX_W-1:0]    got_q, got_d;
  logic [PW-1:0]            p_q, p_d;
  logic [PW-1:0]            lim_q, lim_d;
  logic [PBA_CNT_W-1:0]     rem_q, rem_d;
  logic [WAW-1:0]           w_q, w_d;
  logic [BW-1:0]            b_q, b_d;
  logic                     dcnt_q, dcnt_d;
  logic [WAW-1:0]           clr_q, clr_d;
  logic [MAP_WORD_BITS-1:0] word_q, word_d;
  logic [PBA_CNT_W-1:0]     free_q, free_d;
  logic [PBA_CNT_W-1:0]     used_q, used_d;
  logic [PBA_CNT_W-1:0]     resv_q, resv_d;

  logic                        stop;
  logic                        cur_bit;
  logic                        b_last;
  logic [PBA_PIDX_W-1:0]       pidx;
  logic [PBA_PIDX_W+RCW-1:0]   qprod;
  logic [PW-1:0]               wbase;
  logic [PW-1:0]               scan_ext;
  logic [PBA_CNT_W-1:0]        other;
  logic [PBA_CNT_W-1:0]        other_nxt;

  // A walk ends at the limit page or when the run count is used up.
  assign stop     = (p_q >= lim_q) || (run_q && (rem_q == '0));
  assign cur_bit  = word_q[b_q];
  assign b_last   = (b_q == BLAST_C);
  assign pidx     = p_q[PBA_PIDX_W-1:0];
  assign qprod    = pidx * RECIP_C;
  assign wbase    = PW'(w_q) * WSTEP_C;
  assign scan_ext = PW'(scan_pages_i);
  assign other    = rsel_q ? resv_q : used_q;
  assign other_nxt = set_q ? (other + ONE_C) : (other - ONE_C);

  always_comb begin
    state_d = state_q;
    init_d  = init_q;
    alloc_d = alloc_q;
    run_d   = run_q;
    set_d   = set_q;
    rsel_d  = rsel_q;
    fin_d   = fin_q;
    ok_d    = ok_q;
    got_d   = got_q;
    p_d     = p_q;
    lim_d   = lim_q;
    rem_d   = rem_q;
    w_d     = w_q;
    b_d     = b_q;
    dcnt_d  = dcnt_q;
    clr_d   = clr_q;
    word_d  = word_q;
    free_d  = free_q;
    used_d  = used_q;
    resv_d  = resv_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = w_q;
    mem_wdata_o = word_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = w_q;
    done_o      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          fin_d = 1'b0;
          ok_d  = 1'b0;
          got_d = '0;
          w_d   = '0;
          b_d   = '0;
          case (req_i.action)
            ACT_INIT: begin
              free_d  = total_pages_i;
              used_d  = '0;
              resv_d  = '0;
              init_d  = 1'b1;
              clr_d   = '0;
              state_d = S_CLEAR;
            end
            ACT_ALLOC: begin
              alloc_d = 1'b1;
              run_d   = 1'b0;
              p_d     = '0;
              lim_d   = (scan_ext > MAXP_C) ? MAXP_C : scan_ext;
              state_d = S_READ;
            end
            ACT_FREE, ACT_LOCK, ACT_RESERVE, ACT_UNRESERVE: begin
              alloc_d = 1'b0;
              run_d   = 1'b1;
              set_d   = (req_i.action == ACT_LOCK) || (req_i.action == ACT_RESERVE);
              rsel_d  = (req_i.action == ACT_RESERVE) || (req_i.action == ACT_UNRESERVE);
              p_d     = PW'(req_i.page_index);
              rem_d   = req_i.page_count;
              lim_d   = MAXP_C;
              dcnt_d  = 1'b1;
              state_d = S_DIV;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = '0;
        clr_d       = clr_q + 1'b1;
        if (clr_q == WLAST_C) begin
          init_d  = 1'b0;
          state_d = init_q ? S_DONE : S_IDLE;
        end
      end

      // Splits the start page into word and bit index: first a
      // reciprocal multiply gives the word, then the bit index is what is
      // left of the page after taking away the start of that word.
      S_DIV: begin
        if (dcnt_q) begin
          w_d    = WAW'(qprod >> RSH);
          dcnt_d = 1'b0;
        end else begin
          b_d     = BW'(p_q - wbase);
          state_d = S_READ;
        end
      end

      S_READ: begin
        if (stop) begin
          state_d = S_DONE;
        end else begin
          mem_re_o = 1'b1;
          state_d  = S_LOAD;
        end
      end

      S_LOAD: begin
        word_d = mem_rdata_i;
        if (alloc_q && (&mem_rdata_i)) begin
          // A full word holds no free page; skip it whole.
          w_d     = w_q + 1'b1;
          p_d     = p_q + WSTEP_C;
          state_d = S_READ;
        end else begin
          state_d = S_WALK;
        end
      end

      S_WALK: begin
        if (stop) begin
          fin_d   = 1'b1;
          state_d = S_WRITE;
        end else if (alloc_q && !cur_bit) begin
          word_d[b_q] = 1'b1;
          free_d  = free_q - ONE_C;
          used_d  = used_q + ONE_C;
          got_d   = pidx;
          ok_d    = 1'b1;
          fin_d   = 1'b1;
          state_d = S_WRITE;
        end else begin
          if (run_q && (cur_bit != set_q)) begin
            word_d[b_q] = set_q;
            free_d = set_q ? (free_q - ONE_C) : (free_q + ONE_C);
            if (rsel_q) begin
              resv_d = other_nxt;
            end else begin
              used_d = other_nxt;
            end
          end
          if (run_q) begin
            rem_d = rem_q - ONE_C;
          end
          p_d = p_q + 1'b1;
          if (b_last) begin
            state_d = S_WRITE;
          end else begin
            b_d = b_q + 1'b1;
          end
        end
      end

      S_WRITE: begin
        mem_we_o = 1'b1;
        w_d      = w_q + 1'b1;
        b_d      = '0;
        state_d  = fin_q ? S_DONE : S_READ;
      end

      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      init_q  <= 1'b0;
      clr_q   <= '0;
      free_q  <= '0;
      used_q  <= '0;
      resv_q  <= '0;
      alloc_q <= 1'b0;
      run_q   <= 1'b0;
      fin_q   <= 1'b0;
      ok_q    <= 1'b0;
      got_q   <= '0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      clr_q   <= clr_d;
      free_q  <= free_d;
      used_q  <= used_d;
      resv_q  <= resv_d;
      alloc_q <= alloc_d;
      run_q   <= run_d;
      fin_q   <= fin_d;
      ok_q    <= ok_d;
      got_q   <= got_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_q  <= set_d;
    rsel_q <= rsel_d;
    p_q    <= p_d;
    lim_q  <= lim_d;
    rem_q  <= rem_d;
    w_q    <= w_d;
    b_q    <= b_d;
    dcnt_q <= dcnt_d;
    word_q <= word_d;
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    rsp_o.alloc_page     = got_q;
    rsp_o.alloc_ok       = ok_q;
    rsp_o.free_pages     = free_q;
    rsp_o.used_pages     = used_q;
    rsp_o.reserved_pages = resv_q;
  end

endmodule

`default_nettype wire

/* rtl/core/page_bitmap_allocator.sv */
// Top level of the page bitmap allocator: configuration registers, the
// response register and the sequencer with its map memory. Uses pba_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps one bit per physical page (set means taken) in an on-chip
// memory of MAP_WORD_BITS-wide words, and three 17-bit page counters (free,
// used, reserved) that wrap. A request is taken when start is high and busy
// is low; busy then stays high until the response has been produced, so one
// request is handled at a time. The response appears on rsp_o for exactly one
// cycle with done_o high and cannot be held off, so the receiver must take it
// in that cycle. Every response carries the three counters; alloc_page and
// alloc_ok are only nonzero for a successful allocate.
//
// The work is done by a read/modify/write walk over the map memory:
//   init:      clears every map word, then responds.
//   allocate:  reads the words below the scan limit, skips each completely full
//              word whole, and walks the first word with a free page bit by bit
//              (at most MAP_WORD_BITS pages) until it takes a page or hits the limit.
//   run ops:   splits the first page into word and bit, then walks one page at
//              a time, writing back each map word touched.
//   others:    responds without touching the map.
// After reset the block clears all MAP_WORDS words of the map
// (1024 with the default sizes) and holds busy high meanwhile; configuration
// writes are taken during that pass. Configuration registers should only be
// written while no request is in flight.
module page_bitmap_allocator import pba_pkg::*; #(
  parameter int unsigned MAX_PAGES     = PBA_MAX_PAGES,
  parameter int unsigned MAP_WORD_BITS = PBA_MAP_WORD_BITS
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  input  wire pba_req_t                 req_i,
  output logic                          busy,
  input  wire logic                     cfg_we_i,
  input  wire logic [PBA_CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [PBA_CFG_W-1:0]     cfg_wdata_i,
  output logic                          done_o,
  output pba_rsp_t                      rsp_o
);

  localparam int unsigned MAP_WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int unsigned WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  // Configuration registers.
  logic [PBA_CFG_W-1:0] scan_q, scan_d;
  logic [PBA_CFG_W-1:0] total_q, total_d;

  always_comb begin
    scan_d  = scan_q;
    total_d = total_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCAN_PAGES:  scan_d  = cfg_wdata_i;
        CFG_TOTAL_PAGES: total_d = cfg_wdata_i;
        default: begin
          scan_d  = scan_q;
          total_d = total_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= PBA_CFG_RST;
      total_q <= PBA_CFG_RST;
    end else begin
      scan_q  <= scan_d;
      total_q <= total_d;
    end
  end

  // Sequencer and map memory.
  logic                     seq_start;
  logic                     seq_done;
  pba_rsp_t                 seq_rsp;
  logic                     mem_we;
  logic [WAW-1:0]           mem_waddr;
  logic [MAP_WORD_BITS-1:0] mem_wdata;
  logic                     mem_re;
  logic [WAW-1:0]           mem_raddr;
  logic [MAP_WORD_BITS-1:0] mem_rdata;

  // A request is accepted whenever the sequencer is idle.
  assign seq_start = start && !busy;

  pba_seq #(
    .MAX_PAGES     (MAX_PAGES),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (seq_start),
    .req_i         (req_i),
    .scan_pages_i  (scan_q),
    .total_pages_i (total_q),
    .busy_o        (busy),
    .done_o        (seq_done),
    .rsp_o         (seq_rsp),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  pba_map #(
    .DEPTH (MAP_WORDS),
    .WIDTH (MAP_WORD_BITS),
    .AW    (WAW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Response register: the strobe is cleared by reset, the payload is not.
  logic     done_q;
  pba_rsp_t rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= seq_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_done) begin
      rsp_q <= seq_rsp;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire
